// ===== rtl/rcstg_pkg.sv =====
// shared constants and elaboration-time sine helpers for the rate controlled
// sine table generator; no dependencies
`default_nettype none

package rcstg_pkg;

  localparam int          TABLE_DEPTH_DEFAULT = 10;
  localparam logic [11:0] SPIKE_LIMIT_RESET   = 12'd50;
  localparam logic [5:0]  COUNT_MAX           = 6'd63;

  // hold = |filtered| / 100 via reciprocal, exact for magnitudes up to 2048
  localparam logic [12:0] HOLD_RECIP = 13'd5243;
  localparam int          HOLD_SHIFT = 19;

  // dac command prefix, upper byte of the word
  localparam logic [7:0]  DAC_CMD_HI = 8'b0011_0000;

  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
  localparam logic [63:0] AMPLITUDE   = 64'd125;

  // sine taylor series in q2.30, terms up to phi^11, each term truncated
  function automatic logic [63:0] sin_q30(input logic [63:0] phi);
    logic [63:0]        phi2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    phi2 = (phi * phi) >> 30;
    term = phi;
    sum  = $signed(term);
    term = ((term * phi2) >> 30) / 64'd6;
    sum  = sum - $signed(term);
    term = ((term * phi2) >> 30) / 64'd20;
    sum  = sum + $signed(term);
    term = ((term * phi2) >> 30) / 64'd42;
    sum  = sum - $signed(term);
    term = ((term * phi2) >> 30) / 64'd72;
    sum  = sum + $signed(term);
    term = ((term * phi2) >> 30) / 64'd110;
    sum  = sum - $signed(term);
    return sum;
  endfunction

  // cosine taylor series in q2.30, terms up to phi^12
  function automatic logic [63:0] cos_q30(input logic [63:0] phi);
    logic [63:0]        phi2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    phi2 = (phi * phi) >> 30;
    term = Q30_ONE;
    sum  = $signed(term);
    term = ((term * phi2) >> 30) / 64'd2;
    sum  = sum - $signed(term);
    term = ((term * phi2) >> 30) / 64'd12;
    sum  = sum + $signed(term);
    term = ((term * phi2) >> 30) / 64'd30;
    sum  = sum - $signed(term);
    term = ((term * phi2) >> 30) / 64'd56;
    sum  = sum + $signed(term);
    term = ((term * phi2) >> 30) / 64'd90;
    sum  = sum - $signed(term);
    term = ((term * phi2) >> 30) / 64'd132;
    sum  = sum + $signed(term);
    return sum;
  endfunction

  // table entry from quadrant and in-quadrant angle
  function automatic logic [7:0] wave_entry(input logic [1:0] quad, input logic [63:0] phi);
    logic signed [63:0] s;
    logic signed [63:0] v;
    logic [63:0]        scaled;
    s = quad[0] ? $signed(cos_q30(phi)) : $signed(sin_q30(phi));
    if (quad[1]) begin
      s = -s;
    end
    v = $signed(Q30_ONE) + s;
    if (v < 0) begin
      v = 0;
    end
    if (v > $signed(Q30_ONE << 1)) begin
      v = $signed(Q30_ONE << 1);
    end
    scaled = ($unsigned(v) * AMPLITUDE) >> 30;
    return scaled[7:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rcstg_wave_rom.sv =====
// constant sine table built at elaboration, read combinationally
// depends on rcstg_pkg
`default_nettype none

module rcstg_wave_rom #(
  parameter int TABLE_DEPTH = rcstg_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic [5:0] index,
  output logic [7:0] level
);
  import rcstg_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [6:0] DEPTH7 = 7'(TABLE_DEPTH);

  logic [7:0] rom [TABLE_DEPTH];

  for (genvar x = 0; x < TABLE_DEPTH; x++) begin : g_entry
    localparam int          QUAD = (4 * x) / TABLE_DEPTH;
    localparam int          REM  = (4 * x) % TABLE_DEPTH;
    localparam logic [63:0] PHI  = (PI_HALF_Q30 * 64'(REM)) / TABLE_DEPTH;
    assign rom[x] = wave_entry(2'(QUAD), PHI);
  end

  // out of range index reads entry zero
  always_comb begin
    if ({1'b0, index} < DEPTH7) begin
      level = rom[index[IDX_W-1:0]];
    end else begin
      level = rom[0];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rate_controlled_sine_table_generator.sv =====
// rate controlled sine table generator: spike filter, hold count, table step
// input and result register stages; one beat per cycle unless m_tready stalls
// state update happens in the compute stage, so every beat sees the prior beat's state
// rst (synchronous, active high) clears kept sample, counter, index, level, spike limit to 50
// depends on rcstg_pkg and rcstg_wave_rom
`default_nettype none

module rate_controlled_sine_table_generator #(
  parameter int TABLE_DEPTH = rcstg_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // config write channel: spike_limit
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [11:0] cfg_data,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [11:0] position_sample, [15:12] zero
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [7:0] level, [23:8] dac_word, [29:24] table_position
  output logic [0:0]  m_tuser    // [0] spike_rejected
);
  import rcstg_pkg::*;

  localparam logic [6:0] DEPTH7 = 7'(TABLE_DEPTH);

  // configuration
  logic [11:0] spike_limit;

  // architectural state
  logic signed [11:0] kept_position;
  logic [5:0]         tick_counter;
  logic [5:0]         wave_index;
  logic [7:0]         last_level;

  // input register stage
  logic               in_valid;
  logic signed [11:0] in_sample;

  // result register stage
  logic        out_valid;
  logic [7:0]  out_level;
  logic [15:0] out_dac_word;
  logic [5:0]  out_position;
  logic        out_rejected;

  // pipeline moves when the result slot is free or being drained
  logic advance;
  assign advance   = !out_valid || m_tready;
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = 1'b1;

  // spike filter
  logic signed [12:0] diff;
  logic [12:0]        diff_abs;
  logic               rejected;
  logic signed [11:0] filtered;

  // hold count
  logic [11:0] mag;
  logic [24:0] prod;
  logic [5:0]  quot;
  logic        hold_negative;
  logic [5:0]  hold_mag;
  logic        step_wave;

  // table stepping
  logic [5:0] cur_index;
  logic [5:0] wave_index_next;
  logic [7:0] rom_level;
  logic [7:0] level_next;
  logic [5:0] tick_counter_next;

  always_comb begin
    diff     = 13'(in_sample) - 13'(kept_position);
    diff_abs = diff[12] ? 13'(-diff) : 13'(diff);
    rejected = diff_abs > {1'b0, spike_limit};
    filtered = rejected ? kept_position : in_sample;

    // truncation toward zero: divide the magnitude, sign applied afterwards
    mag  = filtered[11] ? 12'(-filtered) : 12'(filtered);
    prod = 25'(mag) * 25'(HOLD_RECIP);
    quot = prod[HOLD_SHIFT +: 6];

    // a negative hold count is always exceeded; small negatives round to zero
    hold_negative = filtered[11] && (quot != 6'd0);
    hold_mag      = filtered[11] ? 6'd0 : quot;
    step_wave     = hold_negative || (tick_counter > hold_mag);

    cur_index = ({1'b0, wave_index} < DEPTH7) ? wave_index : 6'd0;
    if (step_wave) begin
      wave_index_next = ({1'b0, cur_index} == DEPTH7 - 7'd1) ? 6'd0 : cur_index + 6'd1;
      level_next      = rom_level;
      // counter restarts at zero and then increments
      tick_counter_next = 6'd1;
    end else begin
      wave_index_next   = wave_index;
      level_next        = last_level;
      tick_counter_next = (tick_counter < COUNT_MAX) ? tick_counter + 6'd1 : tick_counter;
    end
  end

  rcstg_wave_rom #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_rom (
    .index (cur_index),
    .level (rom_level)
  );

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      spike_limit <= SPIKE_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      spike_limit <= cfg_data;
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_sample <= s_tdata[11:0];
    end
  end

  // compute stage: state and result update together
  always_ff @(posedge clk) begin
    if (rst) begin
      kept_position <= '0;
      tick_counter  <= '0;
      wave_index    <= '0;
      last_level    <= '0;
      out_valid     <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
      if (in_valid) begin
        kept_position <= filtered;
        tick_counter  <= tick_counter_next;
        wave_index    <= wave_index_next;
        last_level    <= level_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      out_level    <= level_next;
      out_dac_word <= {DAC_CMD_HI, 8'h00} | {4'h0, level_next, 4'h0};
      out_position <= wave_index_next;
      out_rejected <= rejected;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_position, out_dac_word, out_level};
  assign m_tuser  = out_rejected;

endmodule

`default_nettype wire

// ===== tb/rate_controlled_sine_table_generator_tb.sv =====
// self-checking testbench for rate_controlled_sine_table_generator: directed table,
// then random slider walks with spikes, checked beat by beat against a local predictor
// depends on rcstg_pkg and the generator rtl
`default_nettype none

module rate_controlled_sine_table_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rcstg_pkg::*;

  localparam int WAVE_DEPTH      = 10;
  localparam int RESET_CYCLES    = 6;
  localparam int DRAIN_CYCLES    = 8;     // pipeline is two deep, leave some margin
  localparam int WATCHDOG_LIMIT  = 2000;  // well above the long receiver hold-off
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int PHASE_BEATS     = 220;
  localparam int NUM_PHASES      = 6;
  localparam int REPORT_MAX      = 10;

  // sine table for the default depth, entry x = floor(125 * (1 + sin(2*pi*x/10)))
  localparam logic [7:0] SINE_LEVELS [WAVE_DEPTH] =
    '{8'd125, 8'd198, 8'd243, 8'd243, 8'd198, 8'd125, 8'd51, 8'd6, 8'd6, 8'd51};

  // one output beat, unpacked from m_tdata / m_tuser
  typedef struct packed {
    logic [7:0]  level;
    logic [15:0] dac_word;
    logic [5:0]  table_position;
    logic        spike_rejected;
  } wave_beat_t;

  typedef enum logic {ROW_BEAT, ROW_LIMIT} row_kind_t;

  // directed row: a sample beat or a spike limit write, optionally with a typed result
  typedef struct packed {
    row_kind_t  kind;
    logic [11:0] value;
    logic       typed;
    wave_beat_t want;
  } dir_row_t;

  localparam wave_beat_t NO_BEAT = '0;
  localparam int NUM_ROWS = 20;

  localparam dir_row_t DIRECTED [NUM_ROWS] = '{
    // fresh from reset: counter not yet above hold 0, level still zero
    '{ROW_BEAT,  12'd0,      1'b1, '{8'd0,   16'h3000, 6'd0, 1'b0}},
    // counter now above hold, first table entry
    '{ROW_BEAT,  12'd0,      1'b1, '{8'd125, 16'h37d0, 6'd1, 1'b0}},
    // largest positive and negative samples are spikes against zero
    '{ROW_BEAT,  12'd2047,   1'b1, '{8'd198, 16'h3c60, 6'd2, 1'b1}},
    '{ROW_BEAT,  12'(-2048), 1'b1, '{8'd243, 16'h3f30, 6'd3, 1'b1}},
    // exactly at the limit, then one past it
    '{ROW_BEAT,  12'd50,     1'b0, NO_BEAT},
    '{ROW_BEAT,  12'd101,    1'b0, NO_BEAT},
    '{ROW_BEAT,  12'(-1),    1'b0, NO_BEAT},
    // widest limit: full-scale swings pass, longest hold and negative hold
    '{ROW_LIMIT, 12'd4095,   1'b0, NO_BEAT},
    '{ROW_BEAT,  12'd2047,   1'b0, NO_BEAT},
    '{ROW_BEAT,  12'd2047,   1'b0, NO_BEAT},
    '{ROW_BEAT,  12'd2047,   1'b0, NO_BEAT},
    '{ROW_BEAT,  12'(-2048), 1'b0, NO_BEAT},
    '{ROW_BEAT,  12'(-2048), 1'b0, NO_BEAT},
    '{ROW_BEAT,  12'(-99),   1'b0, NO_BEAT},  // hold truncates to zero
    '{ROW_BEAT,  12'd99,     1'b0, NO_BEAT},
    '{ROW_BEAT,  12'd199,    1'b0, NO_BEAT},
    // zero limit: only an identical sample gets through
    '{ROW_LIMIT, 12'd0,      1'b0, NO_BEAT},
    '{ROW_BEAT,  12'd199,    1'b0, NO_BEAT},
    '{ROW_BEAT,  12'd200,    1'b0, NO_BEAT},
    '{ROW_BEAT,  12'(-2048), 1'b0, NO_BEAT}
  };

  logic        clk;
  logic        rst       = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [11:0] cfg_data  = '0;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata   = '0;   // [11:0] position_sample, [15:12] zero
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [31:0] m_tdata;          // [7:0] level, [23:8] dac_word, [29:24] table_position
  logic [0:0]  m_tuser;          // [0] spike_rejected

  // predictor copy of the generator state
  logic        [11:0] limit_now   = SPIKE_LIMIT_RESET;
  logic signed [11:0] kept_pos    = '0;
  logic        [5:0]  ticks_held  = '0;
  logic        [5:0]  wave_idx    = '0;
  logic        [7:0]  held_level  = '0;

  wave_beat_t pending_beats [$];   // expected output beats, oldest first
  int         bad_beats    = 0;
  int         quiet_cycles = 0;

  // idle percentages for both sides, changed between phases
  int send_gap_pct = 0;
  int recv_gap_pct = 0;

  // long receiver hold-off, requested once by the stimulus
  bit stall_go   = 1'b0;
  bit stall_done = 1'b0;
  int stall_left = 0;

  // position walk used by the random stimulus
  int walk_pos = 0;

  rate_controlled_sine_table_generator #(
    .TABLE_DEPTH(WAVE_DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // advance the predicted generator by one position sample, return its output beat
  function automatic wave_beat_t next_wave_beat(input logic [11:0] sample_bits);
    wave_beat_t         beat;
    logic signed [11:0] sample;
    logic signed [11:0] filtered;
    int                 diff;
    int                 hold;
    sample = $signed(sample_bits);
    diff   = int'(sample) - int'(kept_pos);
    if (diff < 0) begin
      diff = -diff;
    end
    beat.spike_rejected = (diff > int'(limit_now));
    filtered = beat.spike_rejected ? kept_pos : sample;
    // int division truncates toward zero, as the hold count needs
    hold = int'(filtered) / 100;
    if (int'(ticks_held) > hold) begin
      if (wave_idx >= WAVE_DEPTH) begin
        wave_idx = '0;
      end
      held_level = SINE_LEVELS[wave_idx];
      wave_idx   = (wave_idx == WAVE_DEPTH - 1) ? 6'd0 : wave_idx + 6'd1;
      ticks_held = '0;
    end
    kept_pos = filtered;
    if (ticks_held != COUNT_MAX) begin
      ticks_held = ticks_held + 6'd1;
    end
    beat.level          = held_level;
    beat.dac_word       = {DAC_CMD_HI, 8'h00} | {4'h0, held_level, 4'h0};
    beat.table_position = wave_idx;
    return beat;
  endfunction

  // offer one sample beat, wait for it to be taken, then queue its result
  task automatic send_position(input logic [11:0] sample, input logic typed,
                               input wave_beat_t want);
    wave_beat_t predicted;
    while ($urandom_range(99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'h0, sample};
    do @(posedge clk); while (!s_tready);
    // the predictor always runs so that its state follows the block
    predicted = next_wave_beat(sample);
    pending_beats.push_back(typed ? want : predicted);
  endtask

  // write the spike limit once the generator has delivered everything
  task automatic write_spike_limit(input logic [11:0] value);
    s_tvalid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    limit_now = value;
  endtask

  // random sample: mostly a slow walk inside the limit, plus spikes and noise
  function automatic logic [11:0] pick_position();
    int pick;
    int span;
    int value;
    pick = $urandom_range(99);
    span = (int'(limit_now) > 300) ? 300 : int'(limit_now);
    if (pick < 65) begin
      walk_pos = walk_pos + int'($urandom_range(2 * span)) - span;
      walk_pos = (walk_pos > 2047) ? 2047 : (walk_pos < -2048) ? -2048 : walk_pos;
      value = walk_pos;
    end else if (pick < 80) begin
      // just past the limit, away from the walk
      value = int'(limit_now) + 1 + int'($urandom_range(40));
      value = $urandom_range(1) ? walk_pos + value : walk_pos - value;
    end else if (pick < 90) begin
      value = int'($urandom_range(4095)) - 2048;
    end else begin
      // right at the limit
      value = $urandom_range(1) ? walk_pos + int'(limit_now) : walk_pos - int'(limit_now);
    end
    value = (value > 2047) ? 2047 : (value < -2048) ? -2048 : value;
    return value[11:0];
  endfunction

  // receiver side: random stalls, plus one long hold-off so the input backs up
  always @(posedge clk) begin
    if (stall_go && !stall_done) begin
      stall_left = HOLD_OFF_CYCLES;
      stall_done = 1'b1;
    end
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  // output checker: every taken beat against the oldest expectation
  always @(posedge clk) begin
    wave_beat_t got;
    wave_beat_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.level          = m_tdata[7:0];
      got.dac_word       = m_tdata[23:8];
      got.table_position = m_tdata[29:24];
      got.spike_rejected = m_tuser[0];
      if (pending_beats.size() == 0) begin
        bad_beats = bad_beats + 1;
        if (bad_beats <= REPORT_MAX) begin
          $display("unexpected output beat: level %0d dac %h pos %0d rej %0d",
                   got.level, got.dac_word, got.table_position, got.spike_rejected);
        end
      end else begin
        want = pending_beats.pop_front();
        if (got.level !== want.level || got.dac_word !== want.dac_word ||
            got.table_position !== want.table_position ||
            got.spike_rejected !== want.spike_rejected) begin
          bad_beats = bad_beats + 1;
          if (bad_beats <= REPORT_MAX) begin
            $display("beat mismatch (exp/got): level %0d/%0d dac %h/%h pos %0d/%0d rej %0d/%0d",
                     want.level, got.level, want.dac_word, got.dac_word,
                     want.table_position, got.table_position,
                     want.spike_rejected, got.spike_rejected);
          end
        end
      end
    end
  end

  // watchdog: too long without any beat or register write means a hang
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    logic [11:0] phase_limit;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed part, light idling on the sender, heavy on the receiver
    send_gap_pct = 7;
    recv_gap_pct = 51;
    for (int row = 0; row < NUM_ROWS; row++) begin
      if (DIRECTED[row].kind == ROW_LIMIT) begin
        write_spike_limit(DIRECTED[row].value);
      end else begin
        send_position(DIRECTED[row].value, DIRECTED[row].typed, DIRECTED[row].want);
      end
    end

    // random phases, each under its own spike limit
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase / 2)
        0: begin
          send_gap_pct = 7;
          recv_gap_pct = 51;
        end
        1: begin
          send_gap_pct = 51;
          recv_gap_pct = 7;
        end
        default: begin
          send_gap_pct = 0;
          recv_gap_pct = 0;
        end
      endcase
      case (phase)
        0:       phase_limit = SPIKE_LIMIT_RESET;
        1:       phase_limit = 12'd0;
        2:       phase_limit = 12'd4095;
        3:       phase_limit = 12'($urandom_range(2, 4094));
        4:       phase_limit = 12'd1;
        default: phase_limit = 12'd300;
      endcase
      write_spike_limit(phase_limit);
      // start the walk where the kept sample is, so it mostly passes the filter
      walk_pos = int'(kept_pos);
      if (phase == 1) begin
        stall_go = 1'b1;
      end
      repeat (PHASE_BEATS) send_position(pick_position(), 1'b0, NO_BEAT);
    end

    s_tvalid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (bad_beats == 0 && pending_beats.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
